### sv/crra_pkg.sv
package crra_pkg;

  // Ring and queue sizing (RECORD_SLOTS must be a power of two)
  localparam int RING_BYTES   = 4096;
  localparam int RECORD_SLOTS = 64;
  localparam int SLOT_W       = $clog2(RECORD_SLOTS);
  localparam int CNT_W        = SLOT_W + 1;

  // Field widths
  localparam int LEN_W  = 13;
  localparam int POS_W  = 12;
  localparam int MODE_W = 2;
  localparam int STAT_W = 3;

  // Record queue entry: padding flag over length
  localparam int REC_W = LEN_W + 1;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_CAPACITY = 3'd0;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CONSUME = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_READ   = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  request_size;
  } crra_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  offset;
    logic [LEN_W-1:0]  length;
  } crra_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WR_REC,
    S_RD_WAIT,
    S_CN_WAIT,
    S_RESP
  } crra_state_t;

endpackage

### sv/crra_ram.sv
module crra_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/contiguous_record_ring_allocator.sv
// Sequence: an accepted request moves from S_IDLE to S_RESP, which loads the output
// register once it is free; a write that pads the ring end first passes S_WR_REC, a
// consume S_CN_WAIT, and a read S_RD_WAIT, staying there while it skips padding.
// New requests stall until the state is back in S_IDLE. The record queue memory takes
// one write and one registered read per cycle. Reset (synchronous, rst_n low) empties
// the ring and sets capacity to the ring size; the queue memories need no clearing pass.
module contiguous_record_ring_allocator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  crra_pkg::crra_in_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output crra_pkg::crra_out_t                out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [crra_pkg::PADDR_W-1:0]       paddr,
  input  logic [crra_pkg::PDATA_W-1:0]       pwdata,
  output logic [crra_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);

  import crra_pkg::*;

  crra_state_t       state_r, state_nxt;
  logic [LEN_W-1:0]  cap_r, cap_nxt;
  logic [POS_W-1:0]  wp_r, wp_nxt;
  logic [POS_W-1:0]  rp_r, rp_nxt;
  logic [LEN_W-1:0]  used_r, used_nxt;
  logic [SLOT_W-1:0] rhead_r, rhead_nxt;
  logic [SLOT_W-1:0] uhead_r, uhead_nxt;
  logic [CNT_W-1:0]  rcount_r, rcount_nxt;
  logic [CNT_W-1:0]  ucount_r, ucount_nxt;
  logic [LEN_W-1:0]  size_r, size_nxt;
  crra_out_t         res_r, res_nxt;
  crra_out_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Memory ports
  logic              rec_we;
  logic [SLOT_W-1:0] rec_waddr;
  logic [REC_W-1:0]  rec_wdata;
  logic [REC_W-1:0]  rec_rdata;
  logic              unc_we;
  logic [SLOT_W-1:0] unc_waddr;
  logic [LEN_W-1:0]  unc_rdata;

  // Write request arithmetic
  logic              accept;
  logic              cfg_wr;
  logic [LEN_W-1:0]  cfg_val;
  logic [LEN_W-1:0]  remain;
  logic [LEN_W-1:0]  pad;
  logic              has_pad;
  logic [LEN_W+1:0]  need_bytes;
  logic [CNT_W+1:0]  need_slots;
  logic [POS_W-1:0]  start;
  logic [LEN_W:0]    wsum;
  logic [LEN_W:0]    wwrap;

  // Read request arithmetic
  logic              e_pad;
  logic [LEN_W-1:0]  e_len;
  logic [POS_W-1:0]  rp_base;
  logic [LEN_W:0]    rsum;
  logic [LEN_W:0]    rwrap;
  logic [LEN_W-1:0]  free_len;
  logic [LEN_W-1:0]  used_freed;

  crra_ram #(.WIDTH(REC_W), .DEPTH(RECORD_SLOTS)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (rhead_nxt),
    .rdata (rec_rdata)
  );

  crra_ram #(.WIDTH(LEN_W), .DEPTH(RECORD_SLOTS)) u_unc_ram (
    .clk   (clk),
    .we    (unc_we),
    .waddr (unc_waddr),
    .wdata (e_len),
    .raddr (uhead_nxt),
    .rdata (unc_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;
  assign prdata    = {{(PDATA_W-LEN_W){1'b0}}, cap_r};
  assign cfg_wr    = psel && penable && pwrite && (paddr == ADDR_CAPACITY);

  // Clamp the written capacity into the legal range
  always_comb begin
    cfg_val = pwdata[LEN_W-1:0];
    if (cfg_val < LEN_W'(2)) begin
      cfg_val = LEN_W'(2);
    end else if (cfg_val > LEN_W'(RING_BYTES)) begin
      cfg_val = LEN_W'(RING_BYTES);
    end
  end

  // Space and slot checks for a write
  always_comb begin
    remain     = cap_r - {1'b0, wp_r};
    has_pad    = (remain <= in_data.request_size);
    pad        = has_pad ? remain : '0;
    need_bytes = {2'b0, used_r} + {2'b0, pad} + {2'b0, in_data.request_size};
    need_slots = {2'b0, rcount_r} + {2'b0, ucount_r} + (has_pad ? (CNT_W+2)'(2) : (CNT_W+2)'(1));
    start      = has_pad ? '0 : wp_r;
    wsum       = {2'b0, start} + {1'b0, in_data.request_size};
    wwrap      = (wsum >= {1'b0, cap_r}) ? wsum - {1'b0, cap_r} : wsum;
  end

  // Head entry of a queue and the freed byte count
  always_comb begin
    e_pad      = rec_rdata[REC_W-1];
    e_len      = rec_rdata[LEN_W-1:0];
    rp_base    = ({1'b0, rp_r} >= cap_r) ? '0 : rp_r;
    rsum       = {2'b0, rp_base} + {1'b0, e_len};
    rwrap      = (rsum >= {1'b0, cap_r}) ? rsum - {1'b0, cap_r} : rsum;
    free_len   = (state_r == S_CN_WAIT) ? unc_rdata : e_len;
    used_freed = (free_len > used_r) ? '0 : used_r - free_len;
  end

  // Sequencer: next state, queue accesses and result
  always_comb begin
    state_nxt     = state_r;
    cap_nxt       = cap_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    used_nxt      = used_r;
    rhead_nxt     = rhead_r;
    uhead_nxt     = uhead_r;
    rcount_nxt    = rcount_r;
    ucount_nxt    = ucount_r;
    size_nxt      = size_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    rec_we        = 1'b0;
    rec_waddr     = rhead_r + rcount_r[SLOT_W-1:0];
    rec_wdata     = {1'b0, in_data.request_size};
    unc_we        = 1'b0;
    unc_waddr     = uhead_r + ucount_r[SLOT_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt   = '0;
          state_nxt = S_RESP;
          case (in_data.mode)
            MODE_WRITE: begin
              res_nxt.length = in_data.request_size;
              if (in_data.request_size > cap_r) begin
                res_nxt.status = ST_TOO_LARGE;
              end else if (need_bytes > {2'b0, cap_r} ||
                           need_slots > (CNT_W+2)'(RECORD_SLOTS)) begin
                res_nxt.status = ST_FULL;
              end else begin
                res_nxt.offset = start;
                used_nxt       = used_r + pad + in_data.request_size;
                wp_nxt         = wwrap[POS_W-1:0];
                rcount_nxt     = rcount_r + CNT_W'(1);
                rec_we         = 1'b1;
                // Padding goes first; the record follows next cycle
                if (has_pad) begin
                  rec_wdata = {1'b1, pad};
                  size_nxt  = in_data.request_size;
                  state_nxt = S_WR_REC;
                end
              end
            end
            MODE_READ: begin
              if (rcount_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                state_nxt = S_RD_WAIT;
              end
            end
            MODE_CONSUME: begin
              if (ucount_r == '0) begin
                res_nxt.status = ST_NO_READ;
              end else begin
                state_nxt = S_CN_WAIT;
              end
            end
            default: begin
              res_nxt = '0;
            end
          endcase
        end
      end

      S_WR_REC: begin
        rec_we     = 1'b1;
        rec_wdata  = {1'b0, size_r};
        rcount_nxt = rcount_r + CNT_W'(1);
        state_nxt  = S_RESP;
      end

      S_RD_WAIT: begin
        // Pop the head entry; the next head is fetched at the same time
        rhead_nxt  = rhead_r + SLOT_W'(1);
        rcount_nxt = rcount_r - CNT_W'(1);
        if (e_pad) begin
          used_nxt = used_freed;
          rp_nxt   = '0;
          if (rcount_r == CNT_W'(1)) begin
            res_nxt.status = ST_EMPTY;
            state_nxt      = S_RESP;
          end
        end else begin
          res_nxt.status = ST_OK;
          res_nxt.offset = rp_base;
          res_nxt.length = e_len;
          rp_nxt         = rwrap[POS_W-1:0];
          if (ucount_r < CNT_W'(RECORD_SLOTS)) begin
            unc_we     = 1'b1;
            ucount_nxt = ucount_r + CNT_W'(1);
          end
          state_nxt = S_RESP;
        end
      end

      S_CN_WAIT: begin
        uhead_nxt      = uhead_r + SLOT_W'(1);
        ucount_nxt     = ucount_r - CNT_W'(1);
        used_nxt       = used_freed;
        res_nxt.status = ST_OK;
        res_nxt.length = unc_rdata;
        state_nxt      = S_RESP;
      end

      S_RESP: begin
        // Hand the result over once the output register is free
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Capacity write empties the ring
    if (cfg_wr) begin
      cap_nxt    = cfg_val;
      wp_nxt     = '0;
      rp_nxt     = '0;
      used_nxt   = '0;
      rhead_nxt  = '0;
      uhead_nxt  = '0;
      rcount_nxt = '0;
      ucount_nxt = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= LEN_W'(RING_BYTES);
      wp_r        <= '0;
      rp_r        <= '0;
      used_r      <= '0;
      rhead_r     <= '0;
      uhead_r     <= '0;
      rcount_r    <= '0;
      ucount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      used_r      <= used_nxt;
      rhead_r     <= rhead_nxt;
      uhead_r     <= uhead_nxt;
      rcount_r    <= rcount_nxt;
      ucount_r    <= ucount_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    size_r <= size_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

endmodule
